// File: rtl/pcc_pkg.sv
// shared constants, beat types and crc byte update for the png chunk crc checker
package pcc_pkg;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [31:0] chunk_length;
      logic [31:0] chunk_type;
      logic [31:0] stored_crc;
      logic [31:0] computed_crc;
      logic        crc_ok;
   } result_type;

   // reflected crc-32 update by one byte, an xor network of eight shift steps
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = {24'd0, crc[7:0] ^ b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ {1'b0, c[31:1]}) : {1'b0, c[31:1]};
      end
      return c ^ {8'd0, crc[31:8]};
   endfunction

endpackage

// File: rtl/pcc_if.sv
// valid/ready channel interfaces for the chunk byte stream and the chunk results
interface pcc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       chunk_start;

   modport source (output valid, output byte_value, output chunk_start, input ready);
   modport sink (input valid, input byte_value, input chunk_start, output ready);
endinterface

interface pcc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] chunk_length;
   logic [31:0] chunk_type;
   logic [31:0] stored_crc;
   logic [31:0] computed_crc;
   logic        crc_ok;

   modport source (output valid, output chunk_length, output chunk_type, output stored_crc,
                   output computed_crc, output crc_ok, input ready);
   modport sink (input valid, input chunk_length, input chunk_type, input stored_crc,
                 input computed_crc, input crc_ok, output ready);
endinterface

// File: rtl/pcc_parser.sv
// chunk parser state and per-byte crc update
module pcc_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         byte_value,
   input  logic               chunk_start,
   output logic               emit,
   output pcc_pkg::result_type result
);

   typedef enum logic [1:0] {
      PH_LENGTH = 2'd0,
      PH_TYPE   = 2'd1,
      PH_DATA   = 2'd2,
      PH_CRC    = 2'd3
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] count_ff, count_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] type_ff, type_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] read_ff, read_in;

   phase_type   phase_b;
   logic [31:0] count_b, length_b, type_b, crc_b, read_b;
   logic [31:0] count_inc;
   logic [31:0] crc_next;
   logic [31:0] read_next;

   always_comb begin
      // resync drops the partial chunk before taking this byte
      if (chunk_start) begin
         phase_b  = PH_LENGTH;
         count_b  = '0;
         length_b = '0;
         type_b   = '0;
         crc_b    = pcc_pkg::CRC_ONES;
         read_b   = '0;
      end else begin
         phase_b  = phase_ff;
         count_b  = count_ff;
         length_b = length_ff;
         type_b   = type_ff;
         crc_b    = crc_ff;
         read_b   = read_ff;
      end

      count_inc = count_b + 32'd1;
      crc_next  = pcc_pkg::crc_byte(crc_b, byte_value);
      read_next = {read_b[23:0], byte_value};

      phase_in  = phase_b;
      count_in  = count_inc;
      length_in = length_b;
      type_in   = type_b;
      crc_in    = crc_b;
      read_in   = read_b;
      emit      = 1'b0;

      unique case (phase_b)
         PH_LENGTH: begin
            length_in = {length_b[23:0], byte_value};
            if (count_inc[31:2] != 30'd0) begin
               phase_in = PH_TYPE;
               count_in = '0;
            end
         end
         PH_TYPE: begin
            type_in = {type_b[23:0], byte_value};
            crc_in  = crc_next;
            if (count_inc[31:2] != 30'd0) begin
               phase_in = (length_b == 32'd0) ? PH_CRC : PH_DATA;
               count_in = '0;
            end
         end
         PH_DATA: begin
            crc_in = crc_next;
            if (count_inc == length_b) begin
               phase_in = PH_CRC;
               count_in = '0;
            end
         end
         PH_CRC: begin
            read_in = read_next;
            if (count_inc[31:2] != 30'd0) begin
               emit      = 1'b1;
               phase_in  = PH_LENGTH;
               count_in  = '0;
               length_in = '0;
               type_in   = '0;
               crc_in    = pcc_pkg::CRC_ONES;
               read_in   = '0;
            end
         end
         default: begin
            phase_in = PH_LENGTH;
         end
      endcase

      result.chunk_length = length_b;
      result.chunk_type   = type_b;
      result.stored_crc   = read_next;
      result.computed_crc = crc_b ^ pcc_pkg::CRC_ONES;
      result.crc_ok       = ((crc_b ^ pcc_pkg::CRC_ONES) == read_next);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_LENGTH;
         count_ff  <= '0;
         length_ff <= '0;
         type_ff   <= '0;
         crc_ff    <= pcc_pkg::CRC_ONES;
         read_ff   <= '0;
      end else if (step) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         type_ff   <= type_in;
         crc_ff    <= crc_in;
         read_ff   <= read_in;
      end
   end

endmodule

// File: rtl/png_chunk_crc_checker.sv
// top level: png chunk parser with crc-32 check, input register and result register
//
//   channel | dir | beat contents
//   req     | in  | byte_value, chunk_start
//   rsp     | out | chunk_length, chunk_type, stored_crc, computed_crc, crc_ok
//
// one byte per cycle unless a waiting result stalls it: a beat is held in the input register,
// then a single table-free crc byte update and the parser step write the state and result register.
// a result is offered once its last crc byte has passed the input register and the parser step.
// reset clears the parser state and both valid flags; no clearing pass.
// a waiting result stalls only a byte that would finish another chunk.
module png_chunk_crc_checker (
   input  logic       clock,
   input  logic       reset,
   pcc_req_if.sink    req_chan,
   pcc_rsp_if.source  rsp_chan
);

   logic                in_valid_ff;
   logic [7:0]          in_byte_ff;
   logic                in_start_ff;
   logic                out_valid_ff;
   pcc_pkg::result_type out_ff;

   logic                emit;
   logic                advance;
   logic                step;
   pcc_pkg::result_type result;

   // the held byte moves on unless it finishes a chunk while the result slot is full
   assign advance = !in_valid_ff || !emit || !out_valid_ff || rsp_chan.ready;
   assign step    = in_valid_ff && advance;
   assign req_chan.ready = advance;

   pcc_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .byte_value  (in_byte_ff),
      .chunk_start (in_start_ff),
      .emit        (emit),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            in_valid_ff <= req_chan.valid;
         end
         if (step && emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         in_byte_ff  <= req_chan.byte_value;
         in_start_ff <= req_chan.chunk_start;
      end
      if (step && emit) begin
         out_ff <= result;
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.chunk_length = out_ff.chunk_length;
   assign rsp_chan.chunk_type   = out_ff.chunk_type;
   assign rsp_chan.stored_crc   = out_ff.stored_crc;
   assign rsp_chan.computed_crc = out_ff.computed_crc;
   assign rsp_chan.crc_ok       = out_ff.crc_ok;

endmodule
